>>> rtl/fxa_pkg.sv
// Package for the fixed-point ALU: command codes and payload structs.
// No dependencies.
package fxa_pkg;

  localparam int unsigned CmdW = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_CMP      = 4'd4,
    CMD_MIN      = 4'd5,
    CMD_MAX      = 4'd6,
    CMD_INC      = 4'd7,
    CMD_DEC      = 4'd8,
    CMD_FROM_INT = 4'd9,
    CMD_TO_INT   = 4'd10
  } fxa_cmd_t;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] whole_number;
  } fxa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               less_than;
    logic               equal_to;
    logic               greater_than;
    logic               divide_by_zero;
  } fxa_out_t;

endpackage

>>> rtl/fxa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with stall enable.
// Depends on fxa_pkg for nothing but house style; carries a result tag whose
// top bit is the valid bit, cleared on reset.
module fxa_div
  import fxa_pkg::*;
#(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  logic [NW-1:0] q_r   [NW+1];
  logic [DW:0]   rem_r [NW+1];
  logic [DW-1:0] d_r   [NW+1];
  logic [TW-1:0] t_r   [NW+1];

  always_comb begin
    q_r[0]   = num;
    rem_r[0] = '0;
    d_r[0]   = den;
    t_r[0]   = tag_in;
  end

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW:0]   rem_nxt;
    assign trial   = {rem_r[s], q_r[s][NW-1]} - {2'b00, d_r[s]};
    assign rem_nxt = trial[DW+1] ? {rem_r[s][DW-1:0], q_r[s][NW-1]} : trial[DW:0];
    always_ff @(posedge clk) begin
      if (!rst_n) t_r[s+1][TW-1] <= 1'b0;
      else if (en) t_r[s+1][TW-1] <= t_r[s][TW-1];
      if (en) begin
        rem_r[s+1]        <= rem_nxt;
        q_r[s+1]          <= {q_r[s][NW-2:0], ~trial[DW+1]};
        d_r[s+1]          <= d_r[s];
        t_r[s+1][TW-2:0]  <= t_r[s][TW-2:0];
      end
    end
  end

  assign quo     = q_r[NW];
  assign tag_out = t_r[NW];

endmodule

>>> rtl/fixed_point_alu.sv
// Fixed-point ALU top level: decode, multiply, divide and result stages.
// Depends on fxa_pkg and fxa_div.
// Every command takes the same path through the divider pipeline, so results stay in order.
// Throughput: one transfer per cycle; the whole pipe advances when the output
// register is empty or being taken. Reset clears the valid bits only.
module fixed_point_alu
  import fxa_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fxa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fxa_out_t out_data
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned NW = W + FRAC_BITS;
  localparam int unsigned DL = NW;
  localparam int unsigned TW = W + 4 + 3;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: sign-extend, compare, simple ops, operand prep
  logic signed [W-1:0] a, b, n;
  assign a = in_data.operand_a[W-1:0];
  assign b = in_data.operand_b[W-1:0];
  assign n = in_data.whole_number[W-1:0];

  localparam logic signed [W-1:0] HiB = (W)'(((64'sd1 <<< (W-1)) - 1) >>> FRAC_BITS);
  localparam logic signed [W-1:0] LoB = -HiB - (W)'(1);

  logic          v1_r;
  logic [W-1:0]  simp_r;
  logic [3:0]    fl_r;
  logic [1:0]    sel_r;      // 0 simple, 1 mul, 2 div
  logic signed [W-1:0] ma_r, mb_r;
  logic [NW-1:0] dn_r;
  logic [W-1:0]  dd_r;
  logic          dneg_r;

  logic [W-1:0]  simp_nxt;
  logic [3:0]    fl_nxt;
  logic [1:0]    sel_nxt;
  logic signed [W:0] tdiv;
  logic signed [NW-1:0] sa;

  always_comb begin
    simp_nxt = '0;
    fl_nxt   = '0;
    sel_nxt  = 2'd0;
    tdiv     = (a < 0) ? ({a[W-1], a} + (W+1)'((1 << FRAC_BITS) - 1)) : {a[W-1], a};
    case (in_data.command)
      CMD_ADD:  simp_nxt = a + b;
      CMD_SUB:  simp_nxt = a - b;
      CMD_MUL:  sel_nxt  = 2'd1;
      CMD_DIV: begin
        if (b == 0) fl_nxt[0] = 1'b1;
        else        sel_nxt   = 2'd2;
      end
      CMD_CMP:  fl_nxt[3:1] = {a < b, a == b, a > b};
      CMD_MIN:  simp_nxt = (a > b) ? b : a;
      CMD_MAX:  simp_nxt = (a > b) ? a : b;
      CMD_INC:  simp_nxt = a + 1'b1;
      CMD_DEC:  simp_nxt = a - 1'b1;
      CMD_FROM_INT: begin
        if (n > HiB)      simp_nxt = HiB <<< FRAC_BITS;
        else if (n < LoB) simp_nxt = LoB <<< FRAC_BITS;
        else              simp_nxt = n <<< FRAC_BITS;
      end
      CMD_TO_INT: simp_nxt = (W)'(tdiv >>> FRAC_BITS);
      default: ;
    endcase
  end

  assign sa = NW'(a) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_valid;
    if (adv) begin
      simp_r <= simp_nxt;
      fl_r   <= fl_nxt;
      sel_r  <= sel_nxt;
      ma_r   <= a;
      mb_r   <= b;
      dn_r   <= sa[NW-1] ? -sa : sa;
      dd_r   <= b[W-1] ? -b : b;
      dneg_r <= a[W-1] ^ b[W-1];
    end
  end

  // stage 2: multiply (registered) then align in following stages
  logic signed [2*W-1:0] prod_r;
  logic [TW-1:0] tag2;
  logic [NW-1:0] quo;
  logic [TW-1:0] tagq;

  always_ff @(posedge clk) begin
    if (adv) prod_r <= ma_r * mb_r;
  end

  assign tag2 = {v1_r, sel_r == 2'd1 ? W'(0) : simp_r, fl_r, sel_r[1] ? {1'b1, dneg_r} : {1'b0, sel_r[0]}};

  // multiply result delayed to match divider depth
  logic [W-1:0] mres_r [DL];
  always_ff @(posedge clk) begin
    if (adv) begin
      mres_r[0] <= W'(prod_r >>> FRAC_BITS);
      for (int i = 1; i < DL; i++) mres_r[i] <= mres_r[i-1];
    end
  end

  fxa_div #(.NW(NW), .DW(W), .TW(TW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(adv), .num(dn_r), .den(dd_r),
    .tag_in(tag2), .tag_out(tagq), .quo(quo)
  );

  // stage 1 tag feeds divider; mul product path is one stage later, so
  // the product delay chain aligns with tq_r, the register after the divider output.
  logic [TW-1:0] tq_r;
  logic [NW-1:0] q_r;
  always_ff @(posedge clk) begin
    if (!rst_n) tq_r[TW-1] <= 1'b0;
    else if (adv) tq_r[TW-1] <= tagq[TW-1];
    if (adv) begin
      tq_r[TW-2:0] <= tagq[TW-2:0];
      q_r          <= quo;
    end
  end

  // output stage
  fxa_out_t res;
  always_comb begin
    res.result_value   = 32'(signed'(tq_r[W+5:6]));
    res.divide_by_zero = tq_r[2];
    res.greater_than   = tq_r[3];
    res.equal_to       = tq_r[4];
    res.less_than      = tq_r[5];
    case (tq_r[1:0])
      2'b01:   res.result_value = 32'(signed'(mres_r[DL-1]));
      2'b10:   res.result_value = 32'(signed'(W'(q_r)));
      2'b11:   res.result_value = 32'(signed'(-W'(q_r)));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= tq_r[TW-1];
    if (adv) out_data <= res;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("ready decoupled from output stage");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_data.less_than, out_data.equal_to,
                              out_data.greater_than}) <= 1)
    else $error("compare flags conflict");

endmodule

>>> bench/fixed_point_alu_test.sv
// Self-checking bench for fixed_point_alu: directed and random items through
// valid/ready channels, results checked against an in-bench predictor.
// Depends on fxa_pkg and the fixed_point_alu RTL.
module fixed_point_alu_test;
  import fxa_pkg::*;

  localparam int unsigned FracBits = 8;
  localparam int unsigned Latency  = 32 + FracBits + 3;
  localparam int unsigned IdleLimit = 4000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  fxa_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  fxa_out_t out_data;

  fxa_out_t    pending_results[$];
  int unsigned accepted_items;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          calm;

  fixed_point_alu u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic fxa_out_t alu_result(input fxa_in_t item);
    fxa_out_t   r;
    longint     a;
    longint     b;
    longint     n;
    longint     wide;
    r = '0;
    a = longint'(item.operand_a);
    b = longint'(item.operand_b);
    n = longint'(item.whole_number);
    case (item.command)
      CMD_ADD: r.result_value = 32'(a + b);
      CMD_SUB: r.result_value = 32'(a - b);
      CMD_MUL: begin
        wide = (a * b) >>> FracBits;
        r.result_value = 32'(wide);
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          wide = (a * (longint'(1) << FracBits)) / b;
          r.result_value = 32'(wide);
        end
      end
      CMD_CMP: begin
        r.less_than    = a < b;
        r.equal_to     = a == b;
        r.greater_than = a > b;
      end
      CMD_MIN: r.result_value = (a > b) ? 32'(b) : 32'(a);
      CMD_MAX: r.result_value = (a > b) ? 32'(a) : 32'(b);
      CMD_INC: r.result_value = 32'(a + 1);
      CMD_DEC: r.result_value = 32'(a - 1);
      CMD_FROM_INT: begin
        if (n > 64'sd2147483647 / (longint'(1) << FracBits))
          wide = 64'sd2147483647 / (longint'(1) << FracBits);
        else if (n < -64'sd2147483648 / (longint'(1) << FracBits))
          wide = -64'sd2147483648 / (longint'(1) << FracBits);
        else
          wide = n;
        r.result_value = 32'(wide * (longint'(1) << FracBits));
      end
      CMD_TO_INT: r.result_value = 32'(a / (longint'(1) << FracBits));
      default: r = '0;
    endcase
    return r;
  endfunction

  // transfers on both channels, expectation store and watchdog
  always @(posedge clk) begin
    fxa_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(alu_result(in_data));
        accepted_items <= accepted_items + 1;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result %h", out_data);
        end else begin
          want = pending_results.pop_front();
          if (out_data !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: value exp %h got %h lt %b/%b eq %b/%b gt %b/%b dz %b/%b",
                       want.result_value, out_data.result_value,
                       want.less_than, out_data.less_than,
                       want.equal_to, out_data.equal_to,
                       want.greater_than, out_data.greater_than,
                       want.divide_by_zero, out_data.divide_by_zero);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("fixed_point_alu test failed");
        $finish;
      end
    end
  end

  // receiver stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input fxa_in_t item);
    int unsigned mark;
    mark = accepted_items;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (accepted_items == mark);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic send_op(input logic [CmdW-1:0] cmd, input logic [31:0] a,
                         input logic [31:0] b, input logic [31:0] n);
    fxa_in_t item;
    item.command      = cmd;
    item.operand_a    = a;
    item.operand_b    = b;
    item.whole_number = n;
    send_item(item);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      3: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_op(CMD_ADD, 32'h7fff_ffff, 32'd1, 32'd0);
    send_op(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_op(CMD_SUB, 32'h8000_0000, 32'd1, 32'd0);
    send_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'd0);
    send_op(CMD_MUL, 32'hffff_ff00, 32'h0000_0080, 32'd0);
    send_op(CMD_MUL, 32'h7fff_ffff, 32'hffff_ffff, 32'd0);
    send_op(CMD_DIV, 32'h0000_0500, 32'd0, 32'd0);
    send_op(CMD_DIV, 32'h8000_0000, 32'hffff_ffff, 32'd0);
    send_op(CMD_DIV, 32'hffff_fd00, 32'h0000_0200, 32'd0);
    send_op(CMD_CMP, 32'd5, 32'd5, 32'd0);
    send_op(CMD_CMP, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
    send_op(CMD_CMP, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
    send_op(CMD_MIN, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
    send_op(CMD_MAX, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
    send_op(CMD_INC, 32'h7fff_ffff, 32'd0, 32'd0);
    send_op(CMD_DEC, 32'h8000_0000, 32'd0, 32'd0);
    send_op(CMD_FROM_INT, 32'd0, 32'd0, 32'h0080_0000);
    send_op(CMD_FROM_INT, 32'd0, 32'd0, 32'h007f_ffff);
    send_op(CMD_FROM_INT, 32'd0, 32'd0, 32'hff7f_ffff);
    send_op(CMD_FROM_INT, 32'd0, 32'd0, 32'h8000_0000);
    send_op(CMD_TO_INT, 32'hffff_fe80, 32'd0, 32'd0);
    send_op(CMD_TO_INT, 32'h7fff_ffff, 32'd0, 32'd0);
    send_op(4'd11, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_op(4'd15, 32'd1, 32'd1, 32'd1);
  endtask

  task automatic test_random(input int unsigned count);
    fxa_in_t item;
    repeat (count) begin
      if ($urandom_range(0, 15) == 0)
        item.command = 4'($urandom_range(11, 15));
      else
        item.command = 4'($urandom_range(CMD_ADD, CMD_TO_INT));
      item.operand_a    = pick_word();
      item.operand_b    = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_word();
      item.whole_number = pick_word();
      send_item(item);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    accepted_items = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    calm           = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(650);
    calm = 1'b1;
    test_random(150);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("fixed_point_alu test passed");
    else
      $display("fixed_point_alu test failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/fxa_pkg.sv
rtl/fxa_div.sv
rtl/fixed_point_alu.sv
bench/fixed_point_alu_test.sv
